### rtl/core/csv_field_unquoter_core_macros.svh
// assertion macros shared by the csv field unquoter checkers
`ifndef CSV_FIELD_UNQUOTER_CORE_MACROS_SVH
`define CSV_FIELD_UNQUOTER_CORE_MACROS_SVH

// same-cycle implication, ignored while reset is active
`define CFU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cfu assertion failed");

// next-cycle implication, ignored while reset is active
`define CFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cfu assertion failed");

// next-cycle implication that also holds through reset
`define CFU_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cfu assertion failed");

`endif

### rtl/core/cfu_pkg.sv
// types and constants shared by the csv field unquoter
package cfu_pkg;

    localparam int unsigned ByteW = 8;

    localparam logic [ByteW-1:0] CharCr    = 8'h0D;
    localparam logic [ByteW-1:0] CharLf    = 8'h0A;
    localparam logic [ByteW-1:0] CharQuote = 8'h22;
    localparam logic [ByteW-1:0] SepReset  = 8'h2C;

    typedef struct packed {
        logic [ByteW-1:0] text_byte;
        logic             last_byte;
    } t_item;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             data_valid;
        logic             field_end;
        logic             record_end;
    } t_result;

endpackage

### rtl/core/cfu_if.sv
// valid/ready channel interfaces for text bytes and tokenized results
interface cfu_in_if
    import cfu_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] text_byte;
    logic             last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface cfu_out_if
    import cfu_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             data_valid;
    logic             field_end;
    logic             record_end;

    modport source (output valid, output data_byte, output data_valid,
                    output field_end, output record_end, input ready);
    modport sink (input valid, input data_byte, input data_valid,
                  input field_end, input record_end, output ready);
endinterface

### rtl/core/cfu_in_stage.sv
// input register holding one text byte request
module cfu_in_stage
    import cfu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/core/cfu_step.sv
// quote, separator and terminator decode with the parser state flags
module cfu_step
    import cfu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [ByteW-1:0] i_sep,
    input  logic             i_advance,
    input  t_item            i_item,
    output t_result          o_result
);

    logic r_in_quoted;
    logic r_quote_pending;
    logic r_after_term;
    logic n_in_quoted;
    logic n_quote_pending;
    logic n_after_term;

    logic             is_quote;
    logic             is_term;
    logic             quoted_eff;
    logic             dropped_term;
    logic             valid;
    logic [ByteW-1:0] data;
    logic             fend;
    logic             rend;

    assign is_quote = (i_item.text_byte == CharQuote);
    assign is_term  = (i_item.text_byte == CharCr) || (i_item.text_byte == CharLf);

    always_comb begin
        n_in_quoted     = r_in_quoted;
        n_quote_pending = 1'b0;
        n_after_term    = r_after_term;
        dropped_term    = 1'b0;
        valid           = 1'b0;
        data            = '0;
        fend            = 1'b0;
        rend            = 1'b0;
        // a pending quote that is not doubled was a lone mode toggle
        quoted_eff      = r_quote_pending ? !r_in_quoted : r_in_quoted;

        if (r_quote_pending && is_quote) begin
            valid        = 1'b1;
            data         = CharQuote;
            n_after_term = 1'b0;
        end else begin
            n_in_quoted = quoted_eff;
            if (is_quote) begin
                n_quote_pending = 1'b1;
                n_after_term    = 1'b0;
            end else if (is_term && !quoted_eff) begin
                if (r_after_term) begin
                    dropped_term = 1'b1;
                end else begin
                    fend         = 1'b1;
                    rend         = 1'b1;
                    n_after_term = 1'b1;
                end
            end else if ((i_item.text_byte == i_sep) && !quoted_eff) begin
                fend         = 1'b1;
                n_after_term = 1'b0;
            end else begin
                valid        = 1'b1;
                data         = i_item.text_byte;
                n_after_term = 1'b0;
            end
        end

        // end of buffer closes everything and starts over
        if (i_item.last_byte) begin
            if (!dropped_term) begin
                fend = 1'b1;
                rend = 1'b1;
            end
            n_in_quoted     = 1'b0;
            n_quote_pending = 1'b0;
            n_after_term    = 1'b1;
        end
    end

    assign o_result.data_byte  = data;
    assign o_result.data_valid = valid;
    assign o_result.field_end  = fend;
    assign o_result.record_end = rend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quoted     <= 1'b0;
            r_quote_pending <= 1'b0;
            r_after_term    <= 1'b1;
        end else if (i_advance) begin
            r_in_quoted     <= n_in_quoted;
            r_quote_pending <= n_quote_pending;
            r_after_term    <= n_after_term;
        end
    end

endmodule

### rtl/core/cfu_out_stage.sv
// result register in front of the output channel
module cfu_out_stage
    import cfu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/core/csv_field_unquoter_core.sv
// csv field unquoter top level
// i_req carries one byte of csv text per request with a last_byte flag that
// marks the end of a buffer. o_res returns exactly one result per request:
// the unquoted content byte with data_valid, plus field_end and record_end.
// a request takes two register stages: the input register feeds the decode,
// whose result lands in the output register that drives o_res.
// one request is taken every cycle while the receiver keeps up; the single
// decode pass per byte sets that figure.
// when o_res stalls, both stages hold and i_req.ready drops once they fill.
// i_cfg_we writes the separator byte (reset value comma); write it only
// while no request is in flight. reset empties both stages and puts the
// parser outside quotes at the start of a record. after a last byte the
// parser returns to that same state for the next buffer.
module csv_field_unquoter_core
    import cfu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [ByteW-1:0] i_cfg_data,
    cfu_in_if.sink           i_req,
    cfu_out_if.source        o_res
);

    logic [ByteW-1:0] r_sep;
    t_item            req_item;
    t_item            s1_item;
    logic             s1_valid;
    logic             s2_ready;
    t_result          s1_result;
    t_result          res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SepReset;
        end else if (i_cfg_we) begin
            r_sep <= i_cfg_data;
        end
    end

    assign req_item.text_byte = i_req.text_byte;
    assign req_item.last_byte = i_req.last_byte;

    cfu_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_item  (req_item),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_item  (s1_item)
    );

    cfu_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sep     (r_sep),
        .i_advance (s1_valid && s2_ready),
        .i_item    (s1_item),
        .o_result  (s1_result)
    );

    cfu_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .o_ready  (s2_ready),
        .i_result (s1_result),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (res_out)
    );

    assign o_res.data_byte  = res_out.data_byte;
    assign o_res.data_valid = res_out.data_valid;
    assign o_res.field_end  = res_out.field_end;
    assign o_res.record_end = res_out.record_end;

endmodule

### rtl/core/cfu_checker.sv
// port-level checks on the csv field unquoter, bound to the top level
`include "csv_field_unquoter_core_macros.svh"

module cfu_checker
    import cfu_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input logic [ByteW-1:0] i_data_byte,
    input logic             i_data_valid,
    input logic             i_field_end,
    input logic             i_record_end
);

    // dropped content reads as zero
    `CFU_ASSERT_IMPL(a_zero_data, i_clk, i_rst_n, i_res_valid && !i_data_valid, i_data_byte == '0)

    // a closed record always closes its field too
    `CFU_ASSERT_IMPL(a_rec_has_field, i_clk, i_rst_n, i_res_valid && i_record_end, i_field_end)

    // reset empties the result register
    `CFU_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_res_valid)

    // a stalled result stays put
    `CFU_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable({i_data_byte, i_data_valid, i_field_end, i_record_end}))

endmodule

bind csv_field_unquoter_core cfu_checker u_cfu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_data_byte  (o_res.data_byte),
    .i_data_valid (o_res.data_valid),
    .i_field_end  (o_res.field_end),
    .i_record_end (o_res.record_end)
);
